[hw/rtl/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants of the column raycaster
// Holds the sine table, the command and status structs and the state codes.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned STEP_Q8 = 26;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_DIV_ANG,
    ST_TRIG,
    ST_STEP,
    ST_CHECK,
    ST_CEIL_INIT,
    ST_DIV_CEIL,
    ST_OUT
  } grc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture input word
    logic ang_start;   // start angle division
    logic ang_step;    // one divider step
    logic ang_finish;  // form ray angle
    logic trig_sin;    // compute dx, dy and start position
    logic trig_cos;    // not used by the datapath
    logic march_step;  // advance distance
    logic march_check; // test cell
    logic ceil_start;  // start ceiling division
    logic ceil_step;   // one divider step
    logic out_load;    // load output register
  } grc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic march_stop;
  } grc_status_t;

  // round(16384*sin(k*pi/128)), k = 0..64
  function automatic logic [14:0] sine_q(input logic [6:0] k);
    logic [14:0] v;
    case (k)
      7'd0: v = 15'd0;      7'd1: v = 15'd402;    7'd2: v = 15'd804;
      7'd3: v = 15'd1205;   7'd4: v = 15'd1606;   7'd5: v = 15'd2006;
      7'd6: v = 15'd2404;   7'd7: v = 15'd2801;   7'd8: v = 15'd3196;
      7'd9: v = 15'd3590;   7'd10: v = 15'd3981;  7'd11: v = 15'd4370;
      7'd12: v = 15'd4756;  7'd13: v = 15'd5139;  7'd14: v = 15'd5520;
      7'd15: v = 15'd5897;  7'd16: v = 15'd6270;  7'd17: v = 15'd6639;
      7'd18: v = 15'd7005;  7'd19: v = 15'd7366;  7'd20: v = 15'd7723;
      7'd21: v = 15'd8076;  7'd22: v = 15'd8423;  7'd23: v = 15'd8765;
      7'd24: v = 15'd9102;  7'd25: v = 15'd9434;  7'd26: v = 15'd9760;
      7'd27: v = 15'd10080; 7'd28: v = 15'd10394; 7'd29: v = 15'd10702;
      7'd30: v = 15'd11003; 7'd31: v = 15'd11297; 7'd32: v = 15'd11585;
      7'd33: v = 15'd11866; 7'd34: v = 15'd12140; 7'd35: v = 15'd12406;
      7'd36: v = 15'd12665; 7'd37: v = 15'd12916; 7'd38: v = 15'd13160;
      7'd39: v = 15'd13395; 7'd40: v = 15'd13623; 7'd41: v = 15'd13842;
      7'd42: v = 15'd14053; 7'd43: v = 15'd14256; 7'd44: v = 15'd14449;
      7'd45: v = 15'd14635; 7'd46: v = 15'd14811; 7'd47: v = 15'd14978;
      7'd48: v = 15'd15137; 7'd49: v = 15'd15286; 7'd50: v = 15'd15426;
      7'd51: v = 15'd15557; 7'd52: v = 15'd15679; 7'd53: v = 15'd15791;
      7'd54: v = 15'd15893; 7'd55: v = 15'd15986; 7'd56: v = 15'd16069;
      7'd57: v = 15'd16143; 7'd58: v = 15'd16207; 7'd59: v = 15'd16261;
      7'd60: v = 15'd16305; 7'd61: v = 15'd16340; 7'd62: v = 15'd16364;
      7'd63: v = 15'd16379; default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage

[hw/rtl/grid_raycast_column_top.sv]
// ----------------------------------------------------------------------------
// grid_raycast_column_top: column raycaster over a wall-bit grid
// A cast runs setup and two 26-step divisions on the single shared divider,
// plus the serial march loop (at most depth_limit/26 rounded up, 316 steps).
// One item at a time. Synchronous reset restores register defaults; map
// rows are undefined.
// ----------------------------------------------------------------------------
module grid_raycast_column_top #(
  parameter int unsigned MAP_WIDTH  = 32,
  parameter int unsigned MAP_HEIGHT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tuser,   // op
  input  logic [47:0] s_tdata,   // column[9:0], row_index[14:10], row_bits[46:15]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // column_out, ceiling_row, floor_row, shade,
                                 // wall_hit, distance
);

  localparam logic [2:0] REG_PX = 3'd0, REG_PY = 3'd1, REG_VA = 3'd2,
    REG_FOV = 3'd3, REG_DL = 3'd4, REG_SW = 3'd5, REG_SH = 3'd6;

  logic [12:0] player_x, player_y, depth_limit;
  logic [15:0] view_angle, field_of_view;
  logic [9:0]  screen_width, screen_height;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= 13'd2048; player_y <= 13'd2048; view_angle <= 16'd0;
      field_of_view <= 16'd6554; depth_limit <= 13'd2560;
      screen_width <= 10'd320; screen_height <= 10'd240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PX:  player_x <= cfg_data[12:0];
        REG_PY:  player_y <= cfg_data[12:0];
        REG_VA:  view_angle <= cfg_data;
        REG_FOV: field_of_view <= cfg_data;
        REG_DL:  depth_limit <= cfg_data[12:0];
        REG_SW:  screen_width <= cfg_data[9:0];
        REG_SH:  screen_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic in_fire;
  assign in_fire = s_tvalid && s_tready;

  // map rows, combinational read for the cell test
  logic [31:0] map_rows [32];
  logic [4:0]  map_addr;
  always_ff @(posedge clk) begin
    if (in_fire && !s_tuser && s_tdata[14:10] < 5'(MAP_HEIGHT > 31 ? 31 : MAP_HEIGHT)
        || in_fire && !s_tuser && MAP_HEIGHT > 31) begin
      map_rows[s_tdata[14:10]] <= s_tdata[46:15];
    end
  end

  grc_pkg::grc_cmd_t    cmd;
  grc_pkg::grc_status_t status;
  logic [9:0] column_out;
  logic [8:0] ceiling_row;
  logic [9:0] floor_row;
  logic [1:0] shade;
  logic       wall_hit;
  logic [12:0] distance;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  grc_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_is_cast(s_tuser),
    .out_free(!m_tvalid || m_tready), .status, .in_ready(s_tready), .cmd
  );

  grc_datapath #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_dp (
    .clk, .rst, .cmd, .column(s_tdata[9:0]), .player_x, .player_y,
    .view_angle, .field_of_view, .depth_limit, .screen_width, .screen_height,
    .map_addr, .map_data(map_rows[map_addr]), .status, .column_out,
    .ceiling_row, .floor_row, .shade, .wall_hit, .distance
  );

  assign m_tdata = {3'd0, distance, wall_hit, shade, floor_row, ceiling_row, column_out};

endmodule

[hw/rtl/grc_ctrl.sv]
// ----------------------------------------------------------------------------
// grc_ctrl: sequencer of the column raycaster
// Steps one cast through angle, trig, march and ceiling division phases.
// ----------------------------------------------------------------------------
module grc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                in_is_cast,
  input  logic                out_free,
  input  grc_pkg::grc_status_t status,
  output logic                in_ready,
  output grc_pkg::grc_cmd_t    cmd
);

  grc_pkg::grc_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= grc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      grc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_is_cast) begin
          cmd.load = 1'b1;
          state_next = grc_pkg::ST_ANGLE;
        end
      end
      grc_pkg::ST_ANGLE: begin
        cmd.ang_start = 1'b1;
        state_next = grc_pkg::ST_DIV_ANG;
      end
      grc_pkg::ST_DIV_ANG: begin
        cmd.ang_step = 1'b1;
        if (status.div_done) begin
          cmd.ang_step = 1'b0;
          cmd.ang_finish = 1'b1;
          state_next = grc_pkg::ST_TRIG;
        end
      end
      grc_pkg::ST_TRIG: begin
        cmd.trig_sin = 1'b1;
        cmd.trig_cos = 1'b1;
        state_next = grc_pkg::ST_STEP;
      end
      grc_pkg::ST_STEP: begin
        if (status.march_stop) begin
          state_next = grc_pkg::ST_CEIL_INIT;
        end else begin
          cmd.march_step = 1'b1;
          state_next = grc_pkg::ST_CHECK;
        end
      end
      grc_pkg::ST_CHECK: begin
        cmd.march_check = 1'b1;
        state_next = grc_pkg::ST_STEP;
      end
      grc_pkg::ST_CEIL_INIT: begin
        cmd.ceil_start = 1'b1;
        state_next = grc_pkg::ST_DIV_CEIL;
      end
      grc_pkg::ST_DIV_CEIL: begin
        cmd.ceil_step = 1'b1;
        if (status.div_done) begin
          cmd.ceil_step = 1'b0;
          state_next = grc_pkg::ST_OUT;
        end
      end
      grc_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = grc_pkg::ST_IDLE;
        end
      end
      default: state_next = grc_pkg::ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/grc_datapath.sv]
// ----------------------------------------------------------------------------
// grc_datapath: arithmetic of the column raycaster
// Angle divider, sine lookup, march position update, cell test and ceiling
// divider, all driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module grc_datapath #(
  parameter int unsigned MAP_WIDTH  = 32,
  parameter int unsigned MAP_HEIGHT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  grc_pkg::grc_cmd_t     cmd,
  input  logic [9:0]           column,
  input  logic [12:0]          player_x,
  input  logic [12:0]          player_y,
  input  logic [15:0]          view_angle,
  input  logic [15:0]          field_of_view,
  input  logic [12:0]          depth_limit,
  input  logic [9:0]           screen_width,
  input  logic [9:0]           screen_height,
  // map row read port
  output logic [4:0]           map_addr,
  input  logic [31:0]          map_data,
  output grc_pkg::grc_status_t  status,
  output logic [9:0]           column_out,
  output logic [8:0]           ceiling_row,
  output logic [9:0]           floor_row,
  output logic [1:0]           shade,
  output logic                 wall_hit,
  output logic [12:0]          distance
);

  localparam int unsigned STEPX = grc_pkg::STEP_Q8;

  // shared restoring divider, 26-bit quotient
  logic [25:0] dv_num;
  logic [25:0] dv_quo;
  logic [25:0] dv_rem;
  logic [24:0] dv_den;
  logic [4:0]  dv_cnt;
  logic [26:0] dv_trial;

  logic [9:0]  col_r;
  logic [15:0] ang;
  logic signed [15:0] dx, dy;
  logic signed [31:0] px, py;
  logic [13:0] ray_dist;
  logic        hit;
  logic        stop;

  assign dv_trial = {dv_rem, dv_num[25]} - {2'b00, dv_den};
  assign status.div_done = (dv_cnt == 5'd0);

  // sine of a 16-bit turn
  function automatic logic signed [15:0] turn_sine(input logic [15:0] a);
    logic [14:0] p;
    logic [14:0] s0, s1, iv;
    logic [22:0] prod;
    logic [15:0] v;
    p = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    s0 = grc_pkg::sine_q(p[14:8]);
    s1 = grc_pkg::sine_q(p[14:8] + 7'd1);
    prod = 23'(s1 - s0) * 23'(p[7:0]);
    iv = (p[14:8] >= 7'd64) ? 15'd16384 : 15'(s0 + prod[22:8]);
    v = {1'b0, iv};
    return a[15] ? -$signed(v) : $signed(v);
  endfunction

  // cell of a Q.22 value, truncation toward zero; negative fraction gives 0
  logic signed [31:0] nx, ny;
  logic [9:0] cx, cy;
  logic       neg_x, neg_y, out_map;
  always_comb begin
    nx = px + 32'(dx) * 32'(STEPX);
    ny = py + 32'(dy) * 32'(STEPX);
  end

  always_comb begin
    neg_x = px[31] && (px[31:22] != 10'h3FF || px[21:0] == 22'd0);
    neg_y = py[31] && (py[31:22] != 10'h3FF || py[21:0] == 22'd0);
    cx = px[31] ? 10'd0 : px[31:22];
    cy = py[31] ? 10'd0 : py[31:22];
    out_map = neg_x || neg_y || (cx >= 10'(MAP_WIDTH)) || (cy >= 10'(MAP_HEIGHT));
  end

  assign map_addr = cy[4:0];

  logic map_bit;
  always_comb begin
    map_bit = 1'b0;
    if (cx < 10'd32 && cy < 10'd32) begin
      map_bit = map_data[cx[4:0]];
    end
  end

  // ceiling math
  logic [13:0] dist_m;
  logic [23:0] h_prod;
  always_comb begin
    dist_m = ray_dist - 14'd512;
    h_prod = 24'(screen_height) * 24'(dist_m);
  end

  logic [1:0] shade_c;
  logic [15:0] d3, d2;
  always_comb begin
    d3 = 16'(ray_dist) * 16'd3;
    d2 = {1'b0, ray_dist, 1'b0};
    if (d3 < 16'(depth_limit)) shade_c = 2'd0;
    else if (d2 < 16'(depth_limit)) shade_c = 2'd1;
    else if (ray_dist < 14'(depth_limit)) shade_c = 2'd2;
    else shade_c = 2'd0;
  end

  assign status.march_stop = stop || (ray_dist >= 14'(depth_limit));

  logic [9:0] wsafe;
  assign wsafe = (screen_width == 10'd0) ? 10'd1 : screen_width;

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= 5'd0;
    end else if (cmd.ang_start) begin
      dv_num <= 26'(col_r) * 26'(field_of_view);
      dv_den <= 25'(wsafe);
      dv_rem <= '0;
      dv_quo <= '0;
      dv_cnt <= 5'd26;
    end else if (cmd.ceil_start) begin
      // short distances give a zero ceiling, divisor kept nonzero
      dv_num <= (ray_dist > 14'd512) ? 26'(h_prod) : 26'd0;
      dv_den <= (ray_dist > 14'd512) ? 25'({ray_dist, 1'b0}) : 25'd1;
      dv_rem <= '0;
      dv_quo <= '0;
      dv_cnt <= 5'd26;
    end else if ((cmd.ang_step || cmd.ceil_step) && dv_cnt != 5'd0) begin
      dv_num <= {dv_num[24:0], 1'b0};
      if (!dv_trial[26]) begin
        dv_rem <= dv_trial[25:0];
        dv_quo <= {dv_quo[24:0], 1'b1};
      end else begin
        dv_rem <= {dv_rem[24:0], dv_num[25]};
        dv_quo <= {dv_quo[24:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 5'd1;
    end
    if (cmd.load) begin
      col_r <= column;
      ray_dist <= '0;
      hit <= 1'b0;
      stop <= 1'b0;
    end
    if (cmd.ang_finish) begin
      ang <= view_angle - {1'b0, field_of_view[15:1]} + dv_quo[15:0];
    end
    if (cmd.trig_sin) begin
      dx <= turn_sine(ang);
      dy <= turn_sine(ang + 16'd16384);
      px <= 32'({player_x, 14'd0});
      py <= 32'({player_y, 14'd0});
    end
    if (cmd.march_step) begin
      ray_dist <= ray_dist + 14'(STEPX);
      px <= nx;
      py <= ny;
    end
    if (cmd.march_check) begin
      if (out_map) begin
        stop <= 1'b1;
        ray_dist <= 14'(depth_limit);
      end else if (map_bit) begin
        stop <= 1'b1;
        hit <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      column_out <= col_r;
      ceiling_row <= dv_quo[8:0];
      floor_row <= screen_height - 10'(dv_quo[9:0]);
      shade <= shade_c;
      wall_hit <= hit;
      distance <= ray_dist[13] ? 13'h1FFF : ray_dist[12:0];
    end
  end

endmodule

[test/grid_raycast_column_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_raycast_column_top_tb: self-checking bench for the column raycaster
// Fills the wall map, then casts columns under a series of view settings.
// A local march predictor computes each column result, compared per field.
// ----------------------------------------------------------------------------
module grid_raycast_column_top_tb;

  localparam int WATCH_LIMIT = 60000;
  localparam logic OP_ROW  = 1'b0;
  localparam logic OP_CAST = 1'b1;
  localparam int REG_PX = 0, REG_PY = 1, REG_VIEW = 2, REG_FOV = 3;
  localparam int REG_DEPTH = 4, REG_SW = 5, REG_SH = 6;

  // quarter-wave sine, Q1.14
  localparam int SINE_TBL [0:64] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590, 3981, 4370, 4756,
    5139, 5520, 5897, 6270, 6639, 7005, 7366, 7723, 8076, 8423, 8765, 9102,
    9434, 9760, 10080, 10394, 10702, 11003, 11297, 11585, 11866, 12140, 12406,
    12665, 12916, 13160, 13395, 13623, 13842, 14053, 14256, 14449, 14635,
    14811, 14978, 15137, 15286, 15426, 15557, 15679, 15791, 15893, 15986,
    16069, 16143, 16207, 16261, 16305, 16340, 16364, 16379, 16384};

  typedef struct packed {
    logic        op;
    logic [9:0]  column;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
  } ray_word_t;

  // fields from the highest bit down, column_out lowest as on m_tdata
  typedef struct packed {
    logic [12:0] distance;
    logic        wall_hit;
    logic [1:0]  shade;
    logic [9:0]  floor_row;
    logic [8:0]  ceiling_row;
    logic [9:0]  column_out;
  } column_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = 1'b0;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  bit          in_taken = 1'b0;

  // view settings seen by the predictor
  int unsigned px_q8 = 2048, py_q8 = 2048, view_ang = 0, fov = 6554;
  int unsigned depth_q8 = 2560, scr_w = 320, scr_h = 240;
  logic [31:0] wall_map [0:31];

  ray_word_t   pending_q [$];
  column_res_t column_want_q [$];
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          err_count = 0, quiet_cycles = 0;

  grid_raycast_column_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  function automatic int quarter_sine(int unsigned p);
    int unsigned i, f;
    i = p >> 8;
    f = p & 8'hFF;
    if (i >= 64) return 16384;
    return SINE_TBL[i] + (((SINE_TBL[i+1] - SINE_TBL[i]) * f) >> 8);
  endfunction

  function automatic int turn_sine(int unsigned a);
    int unsigned q, w;
    int v;
    q = (a >> 14) & 3;
    w = a & 16'h3FFF;
    v = q[0] ? quarter_sine(16384 - w) : quarter_sine(w);
    return q[1] ? -v : v;
  endfunction

  function automatic longint trunc_cell(longint pos);
    if (pos >= 0) return pos >>> 22;
    return -((-pos) >>> 22);
  endfunction

  // march one column ray through the wall map
  function automatic column_res_t cast_column(logic [9:0] col);
    column_res_t r;
    int unsigned w, ang, ray_dist, ceil_v, shd;
    int dx, dy;
    longint cx, cy;
    bit hit, stop;
    w = (scr_w != 0) ? scr_w : 1;
    ang = (view_ang - (fov >> 1) + (int'(col) * fov) / w) & 16'hFFFF;
    dx = turn_sine(ang);
    dy = turn_sine((ang + 16384) & 16'hFFFF);
    ray_dist = 0; hit = 0; stop = 0; ceil_v = 0;
    while (!stop && ray_dist < depth_q8) begin
      ray_dist += 26;
      cx = trunc_cell((longint'(px_q8) << 14) + longint'(dx) * longint'(ray_dist));
      cy = trunc_cell((longint'(py_q8) << 14) + longint'(dy) * longint'(ray_dist));
      if (cx < 0 || cx >= 32 || cy < 0 || cy >= 32) begin
        stop = 1;
        ray_dist = depth_q8;
      end else if (wall_map[cy][cx]) begin
        stop = 1;
        hit = 1;
      end
    end
    if (ray_dist > 512)
      ceil_v = (longint'(scr_h) * (ray_dist - 512)) / (2 * longint'(ray_dist));
    if (ray_dist * 3 < depth_q8) shd = 0;
    else if (ray_dist * 2 < depth_q8) shd = 1;
    else if (ray_dist < depth_q8) shd = 2;
    else shd = 0;
    r.column_out  = col;
    r.ceiling_row = ceil_v[8:0];
    r.floor_row   = 10'(scr_h - ceil_v);
    r.shade       = shd[1:0];
    r.wall_hit    = hit;
    r.distance    = (ray_dist > 8191) ? 13'd8191 : ray_dist[12:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  // input word accepted at the last rising edge
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
  end

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!s_tvalid || in_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tuser  <= pending_q[0].op;
          s_tdata  <= {1'b0, pending_q[0].row_bits, pending_q[0].row_index,
                       pending_q[0].column};
          void'(pending_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on input words, check output words
  always @(posedge clk) begin
    column_res_t got, want;
    if (!rst) begin
      quiet_cycles++;
      if (s_tvalid && s_tready) begin
        quiet_cycles = 0;
        if (s_tuser == OP_ROW)
          wall_map[s_tdata[14:10]] = s_tdata[46:15];
        else
          column_want_q.push_back(cast_column(s_tdata[9:0]));
      end
      if (m_tvalid && m_tready) begin
        quiet_cycles = 0;
        got = m_tdata[44:0];
        if (column_want_q.size() == 0) begin
          $display("unexpected result word for column %0d", got.column_out);
          err_count++;
        end else begin
          want = column_want_q.pop_front();
          if (got.column_out != want.column_out)
            report_mismatch("column_out", got.column_out, want.column_out);
          if (got.ceiling_row != want.ceiling_row)
            report_mismatch("ceiling_row", got.ceiling_row, want.ceiling_row);
          if (got.floor_row != want.floor_row)
            report_mismatch("floor_row", got.floor_row, want.floor_row);
          if (got.shade != want.shade)
            report_mismatch("shade", got.shade, want.shade);
          if (got.wall_hit != want.wall_hit)
            report_mismatch("wall_hit", got.wall_hit, want.wall_hit);
          if (got.distance != want.distance)
            report_mismatch("distance", got.distance, want.distance);
        end
      end
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("grid_raycast_column_top_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_reg(int idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data  <= val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PX:    px_q8    = val & 13'h1FFF;
      REG_PY:    py_q8    = val & 13'h1FFF;
      REG_VIEW:  view_ang = val & 16'hFFFF;
      REG_FOV:   fov      = val & 16'hFFFF;
      REG_DEPTH: depth_q8 = val & 13'h1FFF;
      REG_SW:    scr_w    = val & 10'h3FF;
      REG_SH:    scr_h    = val & 10'h3FF;
      default: ;
    endcase
  endtask

  task automatic push_cast(int col);
    ray_word_t w;
    w = '0;
    w.op = OP_CAST;
    w.column = col[9:0];
    w.row_bits = $urandom;
    w.row_index = 5'($urandom);
    pending_q.push_back(w);
  endtask

  task automatic push_row(int idx, logic [31:0] bits);
    ray_word_t w;
    w.op = OP_ROW;
    w.column = 10'($urandom);
    w.row_index = idx[4:0];
    w.row_bits = bits;
    pending_q.push_back(w);
  endtask

  // wait for the block to drain before touching registers
  task automatic wait_drained();
    wait (pending_q.size() == 0 && column_want_q.size() == 0);
    @(negedge clk);
    wait (!s_tvalid && column_want_q.size() == 0);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [31:0] sparse_row(int phase);
    logic [31:0] b;
    b = $urandom & $urandom & $urandom;
    if (phase % 3 == 0) b = b & $urandom;
    if (phase % 2 == 0) b = b | 32'h8000_0001;
    return b;
  endfunction

  initial begin
    int n;
    int unsigned v;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // every row written before any cast: bordered room
    for (int r = 0; r < 32; r++)
      push_row(r, (r == 0 || r == 31) ? 32'hFFFF_FFFF : 32'h8000_0001);
    // directed: reset settings, column extremes and beyond width
    push_cast(0); push_cast(160); push_cast(319); push_cast(1022); push_cast(1023);
    wait_drained();
    // cardinal views, wide and zero fov, deepest depth
    write_reg(REG_DEPTH, 8191);
    write_reg(REG_FOV, 32768);
    for (int k = 0; k < 4; k++) begin
      write_reg(REG_VIEW, k * 16384);
      push_cast(0); push_cast(160);
      wait_drained();
    end
    write_reg(REG_FOV, 0);
    write_reg(REG_SW, 0);
    write_reg(REG_SH, 1023);
    push_cast(5); push_cast(1023);
    wait_drained();
    // open map: edge reached, negative fraction near the origin
    for (int r = 0; r < 32; r++) push_row(r, 32'h0);
    wait_drained();
    write_reg(REG_PX, 10); write_reg(REG_PY, 8191);
    write_reg(REG_SW, 1); write_reg(REG_SH, 1);
    write_reg(REG_VIEW, 49152);
    push_cast(0);
    wait_drained();
    write_reg(REG_VIEW, 32768);
    push_cast(0);
    wait_drained();
    write_reg(REG_PX, 0); write_reg(REG_PY, 0);
    write_reg(REG_DEPTH, 0);
    push_cast(0);
    wait_drained();
    write_reg(REG_DEPTH, 26);
    push_cast(0);
    wait_drained();

    // random phases under changing settings and idling
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 5)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        3: begin send_idle_pct = 21; recv_stall_pct = 21; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_reg(REG_PX, (ph == 3) ? 0 : (ph == 4) ? 8191 : $urandom_range(8191));
      write_reg(REG_PY, (ph == 3) ? 8191 : $urandom_range(8191));
      write_reg(REG_VIEW, $urandom_range(65535));
      write_reg(REG_FOV, (ph == 5) ? 32768 : $urandom_range(32768));
      v = (ph == 6) ? 8191 : (ph == 7) ? 26 : $urandom_range(3000, 26);
      write_reg(REG_DEPTH, v);
      write_reg(REG_SW, (ph == 8) ? 1023 : (ph == 9) ? 1 : $urandom_range(1023, 1));
      write_reg(REG_SH, (ph == 8) ? 1 : (ph == 9) ? 1023 : $urandom_range(1023, 1));
      for (int r = 0; r < 32; r++) push_row(r, sparse_row(ph));
      n = (ph == 6) ? 60 : 130;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 12)
          push_row($urandom_range(31), ($urandom_range(3) == 0) ? $urandom : sparse_row(ph));
        else
          push_cast($urandom_range(9) == 0 ? $urandom_range(1023) :
                    $urandom_range(scr_w > 0 ? scr_w - 1 : 0));
      end
      wait_drained();
    end

    repeat (50) @(negedge clk);
    if (err_count == 0)
      $display("grid_raycast_column_top_tb: done, clean");
    else
      $display("grid_raycast_column_top_tb: done, errors");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/grc_pkg.sv
hw/rtl/grc_ctrl.sv
hw/rtl/grc_datapath.sv
hw/rtl/grid_raycast_column_top.sv
test/grid_raycast_column_top_tb.sv
